@@ hw/rtl/fbat_pkg.sv @@
// ----------------------------------------------------------------------------
// fbat_pkg
// Shared types and constants of the flow byte accounting table.
// ----------------------------------------------------------------------------
package fbat_pkg;

	// table geometry
	localparam int FLOW_ENTRIES = 8192;
	localparam int PROBE_LIMIT  = 8;
	localparam int IDX_W        = $clog2(FLOW_ENTRIES);
	localparam int PCNT_W       = $clog2(PROBE_LIMIT) + 1;
	localparam int SLOT_W       = 13;

	// header classification
	localparam logic [3:0] IP_V4     = 4'd4;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// hash multipliers
	localparam logic [31:0] HASH_C1 = 32'h85EB_CA6B;
	localparam logic [31:0] HASH_C2 = 32'hC2B2_AE35;
	localparam logic [31:0] HASH_C3 = 32'h7FEB_352D;

	typedef enum logic [2:0] {
		ST_NOT_IPV4    = 3'd0,
		ST_OTHER_PROTO = 3'd1,
		ST_INSERTED    = 3'd2,
		ST_UPDATED     = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_LOAD,
		S_READ,
		S_CHECK,
		S_RESULT
	} state_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic        valid;
		logic [63:0] addr;
		logic [39:0] ports_proto;
		logic [63:0] sent;
		logic [63:0] recv;
		logic [31:0] pid;
	} entry_t;

endpackage

@@ hw/rtl/flow_byte_accounting_table_unit.sv @@
// ----------------------------------------------------------------------------
// flow_byte_accounting_table_unit
// Per-packet IPv4 TCP/UDP flow byte accounting in a hashed table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 8192-entry table once to clear the valid
// marks, one entry a cycle, with in_ready low throughout the sweep. It then
// handles one item at a time. A header that is not IPv4 TCP/UDP goes
// straight to the result state; a counted header passes through the hash
// states HASH1, HASH2 and LOAD, then a read state and a check state per
// probed slot (memory read, then compare and write back), 1 to 8 probes,
// then the result state, which loads the result into the output registers
// once they are free. The registered read of the entry memory is why each
// probe needs its own read state.
module flow_byte_accounting_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        direction,
	input  logic [3:0]  ip_ver,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] src_address,
	input  logic [31:0] dst_address,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [15:0] total_length,
	input  logic [31:0] process_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [12:0] slot,
	output logic [63:0] sent_total,
	output logic [63:0] recv_total,
	output logic [31:0] owner_pid
);

	localparam int IW = fbat_pkg::IDX_W;

	fbat_pkg::state_t  state_q, state_d;
	logic [IW-1:0]     clr_q, idx_q;
	logic [fbat_pkg::PCNT_W-1:0] cnt_q;
	logic              dir_q;
	logic [15:0]       len_q;
	logic [31:0]       pid_q;
	logic [63:0]       key_addr_q;
	logic [39:0]       key_pp_q;
	fbat_pkg::status_t res_status_q;
	logic [IW-1:0]     res_idx_q;
	logic [63:0]       res_sent_q, res_recv_q;
	logic [31:0]       res_pid_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [12:0]       slot_q;
	logic [63:0]       sent_q, recv_q;
	logic [31:0]       pid_out_q;

	logic              accept, is_v4, is_l4, hit, free, last_probe, load_out;
	logic              rd_en, wr_en;
	logic [IW-1:0]     base, wr_addr;
	fbat_pkg::entry_t  rd_data, wr_data, upd;
	logic [63:0]       len_sent, len_recv;
	logic [IW+12:0]    idx_ext;

	// classification and key of the incoming header
	assign accept = in_valid && in_ready;
	assign is_v4  = (ip_ver == fbat_pkg::IP_V4);
	assign is_l4  = (ip_protocol == fbat_pkg::PROTO_TCP) ||
	                (ip_protocol == fbat_pkg::PROTO_UDP);

	fbat_hash u_hash (
		.clk      (clk),
		.key_addr (key_addr_q),
		.key_pp   (key_pp_q),
		.base     (base)
	);

	fbat_table u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// probe compare and entry update
	assign free       = !rd_data.valid;
	assign hit        = rd_data.valid && (rd_data.addr == key_addr_q) &&
	                    (rd_data.ports_proto == key_pp_q);
	assign last_probe = (cnt_q == fbat_pkg::PCNT_W'(fbat_pkg::PROBE_LIMIT - 1));
	assign len_sent   = dir_q ? 64'(len_q) : 64'd0;
	assign len_recv   = dir_q ? 64'd0 : 64'(len_q);

	always_comb begin
		upd.valid       = 1'b1;
		upd.addr        = key_addr_q;
		upd.ports_proto = key_pp_q;
		if (free) begin
			upd.sent = len_sent;
			upd.recv = len_recv;
			upd.pid  = pid_q;
		end else begin
			upd.sent = rd_data.sent + len_sent;
			upd.recv = rd_data.recv + len_recv;
			upd.pid  = rd_data.pid;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbat_pkg::S_CLEAR:  if (clr_q == '1) state_d = fbat_pkg::S_IDLE;
			fbat_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (is_v4 && is_l4) ? fbat_pkg::S_HASH1 : fbat_pkg::S_RESULT;
				end
			end
			fbat_pkg::S_HASH1:  state_d = fbat_pkg::S_HASH2;
			fbat_pkg::S_HASH2:  state_d = fbat_pkg::S_LOAD;
			fbat_pkg::S_LOAD:   state_d = fbat_pkg::S_READ;
			fbat_pkg::S_READ:   state_d = fbat_pkg::S_CHECK;
			fbat_pkg::S_CHECK: begin
				state_d = (free || hit || last_probe) ? fbat_pkg::S_RESULT : fbat_pkg::S_READ;
			end
			fbat_pkg::S_RESULT: if (!out_valid_q || out_ready) state_d = fbat_pkg::S_IDLE;
			default:            state_d = fbat_pkg::S_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = (state_q == fbat_pkg::S_IDLE);
		rd_en    = (state_q == fbat_pkg::S_READ);
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = upd;
		load_out = (state_q == fbat_pkg::S_RESULT) && (!out_valid_q || out_ready);
		unique case (state_q)
			fbat_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			fbat_pkg::S_CHECK: wr_en = free || hit;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbat_pkg::S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fbat_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// item, probe and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q <= direction;
			len_q <= total_length;
			pid_q <= process_id;
			if (direction) begin
				key_addr_q <= {src_address, dst_address};
				key_pp_q   <= {src_port, dst_port, ip_protocol};
			end else begin
				key_addr_q <= {dst_address, src_address};
				key_pp_q   <= {dst_port, src_port, ip_protocol};
			end
			res_status_q <= !is_v4 ? fbat_pkg::ST_NOT_IPV4 : fbat_pkg::ST_OTHER_PROTO;
			res_idx_q    <= '0;
			res_sent_q   <= '0;
			res_recv_q   <= '0;
			res_pid_q    <= '0;
		end
		if (state_q == fbat_pkg::S_LOAD) begin
			idx_q <= base;
			cnt_q <= '0;
		end
		if (state_q == fbat_pkg::S_CHECK) begin
			if (free || hit) begin
				res_status_q <= free ? fbat_pkg::ST_INSERTED : fbat_pkg::ST_UPDATED;
				res_idx_q    <= idx_q;
				res_sent_q   <= upd.sent;
				res_recv_q   <= upd.recv;
				res_pid_q    <= upd.pid;
			end else if (last_probe) begin
				res_status_q <= fbat_pkg::ST_FULL;
			end else begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (load_out) begin
			status_q  <= res_status_q;
			slot_q    <= idx_ext[12:0];
			sent_q    <= res_sent_q;
			recv_q    <= res_recv_q;
			pid_out_q <= res_pid_q;
		end
	end

	assign idx_ext = {13'd0, res_idx_q};

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign sent_total = sent_q;
	assign recv_total = recv_q;
	assign owner_pid  = pid_out_q;

endmodule

@@ hw/rtl/fbat_hash.sv @@
// ----------------------------------------------------------------------------
// fbat_hash
// Two-stage pipelined flow key hash; gives the home slot of a key.
// ----------------------------------------------------------------------------
module fbat_hash (
	input  logic                      clk,
	input  logic [63:0]               key_addr,
	input  logic [39:0]               key_pp,
	output logic [fbat_pkg::IDX_W-1:0] base
);

	logic [63:0] p1, p2, p3;
	logic [31:0] m1_s1, m2_s1, x_s1;
	logic [31:0] h_a, h_b, m3_s2, h_c;

	// first stage: key multiplies
	assign p1 = 64'(key_addr[31:0]) * 64'(fbat_pkg::HASH_C1);
	assign p2 = 64'(key_pp[39:8]) * 64'(fbat_pkg::HASH_C2);

	always_ff @(posedge clk) begin
		m1_s1 <= p1[31:0];
		m2_s1 <= p2[31:0];
		x_s1  <= key_addr[63:32] ^ 32'(key_pp[7:0]);
	end

	// second stage: fold and mix multiply
	assign h_a = x_s1 ^ m1_s1 ^ m2_s1;
	assign h_b = h_a ^ (h_a >> 16);
	assign p3  = 64'(h_b) * 64'(fbat_pkg::HASH_C3);

	always_ff @(posedge clk) begin
		m3_s2 <= p3[31:0];
	end

	// final fold, slot is the low bits
	assign h_c  = m3_s2 ^ (m3_s2 >> 15);
	assign base = h_c[fbat_pkg::IDX_W-1:0];

endmodule

@@ hw/rtl/fbat_table.sv @@
// ----------------------------------------------------------------------------
// fbat_table
// Flow entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbat_table (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [fbat_pkg::IDX_W-1:0] rd_addr,
	output fbat_pkg::entry_t           rd_data,
	input  logic                       wr_en,
	input  logic [fbat_pkg::IDX_W-1:0] wr_addr,
	input  fbat_pkg::entry_t           wr_data
);

	fbat_pkg::entry_t mem [fbat_pkg::FLOW_ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/fbat_checker.sv @@
// ----------------------------------------------------------------------------
// fbat_checker
// Port-level checks of the flow accounting table, bound to the top level.
// ----------------------------------------------------------------------------
module fbat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [12:0] slot,
	input logic [63:0] sent_total,
	input logic [63:0] recv_total,
	input logic [31:0] owner_pid
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(sent_total))
		else $error("stalled result changed");

	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(fbat_pkg::ST_FULL))
		else $error("bad status code");

	// uncounted items carry zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 3'(fbat_pkg::ST_NOT_IPV4) ||
		status == 3'(fbat_pkg::ST_OTHER_PROTO) || status == 3'(fbat_pkg::ST_FULL))
		|-> slot == 13'd0 && sent_total == 64'd0 && recv_total == 64'd0 &&
		owner_pid == 32'd0)
		else $error("uncounted item with nonzero fields");

	// a new flow has one count empty
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 3'(fbat_pkg::ST_INSERTED) |->
		sent_total == 64'd0 || recv_total == 64'd0)
		else $error("inserted flow with both counts set");

endmodule

bind flow_byte_accounting_table_unit fbat_checker u_fbat_checker (.*);

@@ dv/flow_byte_accounting_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// flow byte accounting table testbench
// Drives packet headers into the flow table, predicts each result with a
// software copy of the hashed table and compares every result field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one packet header
	typedef struct {
		logic        dir;
		logic [3:0]  ver;
		logic [7:0]  proto;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [15:0] len;
		logic [31:0] pid;
	} pkt_t;

	// one flow table answer
	typedef struct {
		fbat_pkg::status_t st;
		logic [12:0] slot;
		logic [63:0] sent;
		logic [63:0] recv;
		logic [31:0] pid;
	} answer_t;

	// table copy and queue of expected answers
	class flow_scoreboard;
		bit          used [fbat_pkg::FLOW_ENTRIES];
		logic [63:0] addr [fbat_pkg::FLOW_ENTRIES];
		logic [39:0] pp   [fbat_pkg::FLOW_ENTRIES];
		logic [63:0] sent [fbat_pkg::FLOW_ENTRIES];
		logic [63:0] recv [fbat_pkg::FLOW_ENTRIES];
		logic [31:0] owner[fbat_pkg::FLOW_ENTRIES];
		answer_t     pending[$];
		int          mismatches;
		int          n_ins, n_upd, n_full, n_skip;

		function logic [31:0] flow_hash(logic [31:0] ks, logic [31:0] kd,
				logic [15:0] ksp, logic [15:0] kdp, logic [7:0] pr);
			logic [31:0] h;
			h = ks ^ (kd * fbat_pkg::HASH_C1) ^ ({ksp, kdp} * fbat_pkg::HASH_C2) ^
				{24'd0, pr};
			h = h ^ (h >> 16);
			h = h * fbat_pkg::HASH_C3;
			h = h ^ (h >> 15);
			return h;
		endfunction

		// update the table copy for one accepted header
		function void note_packet(pkt_t p);
			answer_t     a;
			logic [31:0] ks, kd;
			logic [15:0] ksp, kdp;
			logic [63:0] ka;
			logic [39:0] kp;
			int          b, idx;
			a = '{fbat_pkg::ST_FULL, 0, 0, 0, 0};
			if (p.ver != fbat_pkg::IP_V4) begin
				a.st = fbat_pkg::ST_NOT_IPV4;
				n_skip++;
			end else if (p.proto != fbat_pkg::PROTO_TCP && p.proto != fbat_pkg::PROTO_UDP) begin
				a.st = fbat_pkg::ST_OTHER_PROTO;
				n_skip++;
			end else begin
				if (p.dir) begin
					ks = p.sa; kd = p.da; ksp = p.sp; kdp = p.dp;
				end else begin
					ks = p.da; kd = p.sa; ksp = p.dp; kdp = p.sp;
				end
				ka = {ks, kd};
				kp = {ksp, kdp, p.proto};
				b = flow_hash(ks, kd, ksp, kdp, p.proto) % fbat_pkg::FLOW_ENTRIES;
				for (int i = 0; i < fbat_pkg::PROBE_LIMIT; i++) begin
					idx = (b + i) % fbat_pkg::FLOW_ENTRIES;
					if (!used[idx]) begin
						used[idx] = 1; addr[idx] = ka; pp[idx] = kp;
						sent[idx] = p.dir ? 64'(p.len) : 64'd0;
						recv[idx] = p.dir ? 64'd0 : 64'(p.len);
						owner[idx] = p.pid;
						a.st = fbat_pkg::ST_INSERTED;
					end else if (addr[idx] == ka && pp[idx] == kp) begin
						if (p.dir) sent[idx] += 64'(p.len);
						else recv[idx] += 64'(p.len);
						a.st = fbat_pkg::ST_UPDATED;
					end else
						continue;
					a.slot = idx[12:0];
					a.sent = sent[idx];
					a.recv = recv[idx];
					a.pid = owner[idx];
					break;
				end
				if (a.st == fbat_pkg::ST_FULL) n_full++;
				else if (a.st == fbat_pkg::ST_INSERTED) n_ins++;
				else n_upd++;
			end
			pending.push_back(a);
		endfunction

		// compare one result with the oldest expectation
		function void check_answer(answer_t got);
			answer_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d", got.st);
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st || got.slot !== e.slot || got.sent !== e.sent ||
					got.recv !== e.recv || got.pid !== e.pid) begin
				mismatches++;
				if (mismatches <= 10)
					$display("exp st=%0d slot=%0d s=%h r=%h pid=%h / got st=%0d slot=%0d s=%h r=%h pid=%h",
						e.st, e.slot, e.sent, e.recv, e.pid,
						got.st, got.slot, got.sent, got.recv, got.pid);
			end
		endfunction
	endclass

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic        direction = 0;
	logic [3:0]  ip_ver = 0;
	logic [7:0]  ip_protocol = 0;
	logic [31:0] src_address = 0, dst_address = 0, process_id = 0;
	logic [15:0] src_port = 0, dst_port = 0, total_length = 0;
	logic [2:0]  status;
	logic [12:0] slot;
	logic [63:0] sent_total, recv_total;
	logic [31:0] owner_pid;

	flow_byte_accounting_table_unit i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	flow_scoreboard sb = new();
	bit  sending = 1;
	bit  hold_off = 0;
	int  idle_cycles = 0;
	pkt_t flows[$];

	// present one header and wait for its acceptance
	task automatic send_packet(pkt_t p);
		in_valid <= 1;
		direction <= p.dir; ip_ver <= p.ver; ip_protocol <= p.proto;
		src_address <= p.sa; dst_address <= p.da; src_port <= p.sp;
		dst_port <= p.dp; total_length <= p.len; process_id <= p.pid;
		do @(posedge clk); while (!in_ready);
		sb.note_packet(p);
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	function automatic pkt_t rand_packet();
		pkt_t p;
		p.dir = 1'($urandom_range(1)); p.ver = 4'($urandom); p.proto = 8'($urandom);
		p.sa = $urandom; p.da = $urandom; p.sp = 16'($urandom); p.dp = 16'($urandom);
		p.len = 16'($urandom); p.pid = $urandom;
		return p;
	endfunction

	// counted header: often a known flow in either direction
	function automatic pkt_t flow_packet();
		pkt_t p, f;
		p = rand_packet();
		p.ver = fbat_pkg::IP_V4;
		p.proto = $urandom_range(1) ? fbat_pkg::PROTO_TCP : fbat_pkg::PROTO_UDP;
		if (flows.size() > 0 && $urandom_range(2) != 0) begin
			f = flows[$urandom_range(flows.size() - 1)];
			p.proto = f.proto;
			if (p.dir == f.dir) begin
				p.sa = f.sa; p.da = f.da; p.sp = f.sp; p.dp = f.dp;
			end else begin
				p.sa = f.da; p.da = f.sa; p.sp = f.dp; p.dp = f.sp;
			end
		end else
			flows.push_back(p);
		return p;
	endfunction

	// fills one probe window by searching keys whose hash shares a base slot
	task automatic fill_window();
		pkt_t p;
		int   b, n;
		p = flow_packet();
		p.ver = fbat_pkg::IP_V4; p.proto = fbat_pkg::PROTO_UDP; p.dir = 1;
		b = sb.flow_hash(p.sa, p.da, p.sp, p.dp, p.proto) % fbat_pkg::FLOW_ENTRIES;
		n = 0;
		for (int k = 0; n < fbat_pkg::PROBE_LIMIT + 2 && k < 2000000; k++) begin
			p.sp = k[15:0]; p.dp = k[31:16];
			if (sb.flow_hash(p.sa, p.da, p.sp, p.dp, p.proto) % fbat_pkg::FLOW_ENTRIES == b)
			begin
				p.len = (n == 0) ? 16'hFFFF : 16'($urandom);
				send_packet(p);
				n++;
			end
		end
	endtask

	// receiver stalls, with one long hold-off
	always @(negedge clk) begin
		if (hold_off) out_ready <= 0;
		else out_ready <= ($urandom_range(3) != 0) || sending == 0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_answer('{fbat_pkg::status_t'(status), slot, sent_total, recv_total,
				owner_pid});
	end

	// watchdog on cycles with no acceptance
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 50000) begin
			$display("timeout");
			$display("flow_byte_accounting_table_unit: mismatch");
			$finish;
		end
	end

	initial begin
		pkt_t p;
		int   burst;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// directed: classification, extremes, repeated flow, full window
		p = '{0, 4'hF, fbat_pkg::PROTO_TCP, 0, 0, 0, 0, 0, 0};
		send_packet(p);
		p = '{1, 4'h0, 8'hFF, '1, '1, '1, '1, '1, '1};
		send_packet(p);
		p = '{1, fbat_pkg::IP_V4, 8'd0, '1, '1, '1, '1, '1, '1};
		send_packet(p);
		p = '{0, fbat_pkg::IP_V4, 8'hFF, 1, 2, 3, 4, 5, 6};
		send_packet(p);
		p = '{1, fbat_pkg::IP_V4, fbat_pkg::PROTO_TCP, '1, '1, '1, '1, '1, '1};
		send_packet(p);
		p.dir = 0;
		send_packet(p);
		p = '{0, fbat_pkg::IP_V4, fbat_pkg::PROTO_UDP, 0, 0, 0, 0, 0, 0};
		send_packet(p);
		p = '{1, fbat_pkg::IP_V4, fbat_pkg::PROTO_TCP, 32'h0A000001, 32'hC0A80001,
			1234, 80, 1500, 77};
		send_packet(p);
		p = '{0, fbat_pkg::IP_V4, fbat_pkg::PROTO_TCP, 32'hC0A80001, 32'h0A000001,
			80, 1234, 9000, 5};
		send_packet(p);
		fill_window();

		// long receiver hold-off while headers keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++) send_packet(flow_packet());
		join

		// random bursts with gaps
		for (int i = 0; i < 830; i += burst) begin
			burst = $urandom_range(1, 30);
			for (int j = 0; j < burst; j++)
				send_packet(($urandom_range(9) < 8) ? flow_packet() : rand_packet());
			if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 20));
		end
		in_valid <= 0;
		sending = 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("headers: %0d inserts, %0d updates, %0d table full, %0d not counted",
			sb.n_ins, sb.n_upd, sb.n_full, sb.n_skip);
		if (sb.mismatches == 0)
			$display("flow_byte_accounting_table_unit: match");
		else
			$display("flow_byte_accounting_table_unit: mismatch");
		$finish;
	end
endmodule
